FILE: rtl/swsd_pkg.sv
package swsd_pkg;

  localparam int SEQ_COUNT  = 16;
  localparam int SEQ_W      = $clog2(SEQ_COUNT);
  localparam int STAMP_BITS = 8;
  localparam int MAX_WINDOW = 8;
  localparam int EFF_MAX    = (MAX_WINDOW < SEQ_COUNT - 1) ? MAX_WINDOW : SEQ_COUNT - 1;
  localparam int CNT_W      = $clog2(EFF_MAX + 1);

  localparam int OP_W       = 2;
  localparam int ACK_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int OUT_SEQ_W  = 4;
  localparam int WIN_W      = 4;
  localparam int TMO_W      = 7;
  localparam int CMP_W      = (STAMP_BITS > TMO_W) ? STAMP_BITS : TMO_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_SENT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ACK_OK    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ACK_UNEXP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACK_OUT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_RETX      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_QUIET     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET  = 4'd4;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 7'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic retx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_none;
    logic out_free;
    logic retx_due;
    logic retx_last;
  } dp_stat_t;

  // modular add of two sequence numbers, both below SEQ_COUNT
  function automatic logic [SEQ_W-1:0] seq_add(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    if (t >= (SEQ_W+1)'(SEQ_COUNT)) t = t - (SEQ_W+1)'(SEQ_COUNT);
    return t[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] seq_sub(input logic [SEQ_W-1:0] a,
                                                input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) t = t + (SEQ_W+1)'(SEQ_COUNT);
    return t[SEQ_W-1:0];
  endfunction

endpackage

FILE: rtl/swsd_ctrl.sv
module swsd_ctrl import swsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    RETX
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r, stall_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = EXEC;
        end
      end
      EXEC: begin
        if (stat.op_none) begin
          state_nxt = IDLE;
        end else if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.retx_due ? RETX : IDLE;
        end
      end
      RETX: begin
        // one retransmit word per free output slot
        if (stat.out_free) begin
          cmd.retx = 1'b1;
          if (stat.retx_last) state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
    stall_nxt = (state_nxt != IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= stall_nxt;
    end
  end

  assign in_stall = stall_r;

endmodule

FILE: rtl/swsd_dp.sv
module swsd_dp import swsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [OP_W-1:0]       in_op,
  input  logic [ACK_W-1:0]      in_ack_seq,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_SEQ_W-1:0]  out_seq,
  output logic                  out_last,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat
);

  logic [OP_W-1:0]       op_r;
  logic [ACK_W-1:0]      ack_r;
  logic [WIN_W-1:0]      win_r;
  logic [TMO_W-1:0]      tmo_r;
  logic [SEQ_W-1:0]      oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      outst_r, outst_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [STAMP_BITS-1:0] tick_r, tick_nxt;
  logic [STAMP_BITS-1:0] stamps_r [SEQ_COUNT];

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OUT_SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  stamp_we;
  logic [SEQ_W-1:0]      stamp_addr;

  logic [CNT_W-1:0]      eff_win;
  logic [SEQ_W-1:0]      next_seq;
  logic [SEQ_W-1:0]      ack_s;
  logic [SEQ_W-1:0]      ack_off;
  logic                  ack_in_range;
  logic [STAMP_BITS-1:0] tick_inc;
  logic [STAMP_BITS-1:0] elapsed;
  logic                  retx_due;
  logic                  retx_last;
  logic [SEQ_W-1:0]      retx_seq;
  logic                  out_free;

  always_comb begin
    eff_win      = (int'(win_r) > EFF_MAX) ? CNT_W'(EFF_MAX) : CNT_W'(win_r);
    next_seq     = seq_add(oldest_r, SEQ_W'(outst_r));
    ack_in_range = (int'(ack_r) < SEQ_COUNT);
    ack_s        = SEQ_W'(ack_r);
    ack_off      = seq_sub(ack_s, oldest_r);
    tick_inc     = tick_r + STAMP_BITS'(1);
    // elapsed time against the oldest frame, after this tick
    elapsed      = tick_inc - stamps_r[oldest_r];
    retx_due     = (op_r == OP_TICK) && (outst_r != '0) &&
                   (CMP_W'(elapsed) >= CMP_W'(tmo_r));
    retx_last    = (idx_r == outst_r - CNT_W'(1));
    retx_seq     = seq_add(oldest_r, SEQ_W'(idx_r));
    out_free     = !out_valid_r || !out_stall;
  end

  always_comb begin
    oldest_nxt     = oldest_r;
    outst_nxt      = outst_r;
    idx_nxt        = idx_r;
    tick_nxt       = tick_r;
    stamp_we       = 1'b0;
    stamp_addr     = next_seq;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_seq_nxt    = out_seq_r;
    out_last_nxt   = out_last_r;

    if (cmd.exec) begin
      case (op_r)
        OP_SEND: begin
          out_valid_nxt = 1'b1;
          out_seq_nxt   = OUT_SEQ_W'(next_seq);
          out_last_nxt  = 1'b1;
          if (outst_r >= eff_win) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_SENT;
            stamp_we       = 1'b1;
            outst_nxt      = outst_r + CNT_W'(1);
          end
        end
        OP_ACK: begin
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = OUT_SEQ_W'(ack_r);
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_ACK_OUT;
          // only the oldest pending frame is acked; acks of later ones report unexpected
          if (ack_in_range && outst_r != '0) begin
            if (ack_off == '0) begin
              out_status_nxt = ST_ACK_OK;
              oldest_nxt     = seq_add(oldest_r, SEQ_W'(1));
              outst_nxt      = outst_r - CNT_W'(1);
            end else if (SEQ_W'(outst_r) > ack_off) begin
              out_status_nxt = ST_ACK_UNEXP;
            end
          end
        end
        OP_TICK: begin
          tick_nxt = tick_inc;
          if (retx_due) begin
            idx_nxt = '0;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_QUIET;
            out_seq_nxt    = '0;
            out_last_nxt   = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (cmd.retx) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_RETX;
      out_seq_nxt    = OUT_SEQ_W'(retx_seq);
      out_last_nxt   = retx_last;
      stamp_we       = 1'b1;
      stamp_addr     = retx_seq;
      idx_nxt        = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_RESET;
      tmo_r       <= TIMEOUT_RESET;
      oldest_r    <= '0;
      outst_r     <= '0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == REG_WINDOW)  win_r <= cfg_wdata[WIN_W-1:0];
      if (cfg_we && cfg_idx == REG_TIMEOUT) tmo_r <= cfg_wdata[TMO_W-1:0];
      oldest_r    <= oldest_nxt;
      outst_r     <= outst_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      ack_r <= in_ack_seq;
    end
    if (stamp_we) stamps_r[stamp_addr] <= tick_r;
    idx_r        <= idx_nxt;
    out_status_r <= out_status_nxt;
    out_seq_r    <= out_seq_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    stat.op_none   = !(op_r == OP_SEND || op_r == OP_ACK || op_r == OP_TICK);
    stat.out_free  = out_free;
    stat.retx_due  = retx_due;
    stat.retx_last = retx_last;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_seq    = out_seq_r;
  assign out_last   = out_last_r;

endmodule

FILE: rtl/sliding_window_sender.sv
// Sender-side control of a sliding-window ARQ link.
// Input channel (in_valid / in_stall): one word per event, in_op selects
// send, ack or timer tick; in_ack_seq carries the acked sequence number.
// Output channel (out_valid / out_stall): result words with a status code,
// a sequence number and out_last marking the final word of an event.
// A send or an ack gives one word, a quiet tick gives one word, a tick that
// times out gives one retransmit word per outstanding frame, oldest first.
// An accepted word is registered in op_r and ack_r and decided in the EXEC
// state once the output register is free; its result is then written to the
// output register and the input frees up in the same cycle. A timed-out tick
// then walks the RETX state, which emits one retransmit frame per cycle
// through the output register while the output does not stall.
// An unused opcode gives no result and frees the input without waiting.
// A stalled output holds its word; the next event is still taken and waits
// in decode until the output register frees up.
// Config port (cfg_we, cfg_idx, cfg_wdata) writes window size (index 0) and
// timeout (index 1); the user writes only while block is idle; unenforced.
// Reset (rst_n low, synchronous) empties the window, zeroes the tick
// counter and restores window size 4 and timeout 3.
module sliding_window_sender import swsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_op,
  input  logic [ACK_W-1:0]      in_ack_seq,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_SEQ_W-1:0]  out_seq,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  swsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swsd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_op),
    .in_ack_seq (in_ack_seq),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_seq    (out_seq),
    .out_last   (out_last),
    .cmd        (cmd),
    .stat       (stat)
  );

  // an accepted event always holds off the next one by raising in_stall in the following cycle
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted word");

  // only retransmit words may leave last low
  a_notlast_retx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_RETX)
    else $error("non-final word that is not a retransmit");

  // while a retransmit walk is unfinished no new event is taken
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> in_stall)
    else $error("input accepted during a retransmit walk");

endmodule
